[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/mhpq_pkg.sv]
// package of types and constants for the min-heap priority queue
`default_nettype none
package mhpq_pkg;
    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic signed [31:0] KEY_NONE = 32'sh7FFF_FFFF;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_BADINDEX = 3'd3;
    localparam logic [2:0] ST_LARGER = 3'd4;

    // datapath operations chosen by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request
        OP_RD_CUR,    // read entry at cursor
        OP_RD_LAST,   // read last entry
        OP_RD_PAR,    // read parent of cursor
        OP_RD_LEFT,   // read left child
        OP_RD_RIGHT,  // read right child
        OP_WR_KEY,    // write held key at cursor
        OP_SWAP_UP,   // write parent at cursor, cursor to parent
        OP_SWAP_DN,   // write child at cursor, cursor to child
        OP_CNT_INC,
        OP_CNT_DEC,
        OP_RD_ROOT    // read root for the result
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] status;
        logic       set_status;
    } t_cmd;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic       idx_bad;
        logic       cur_zero;
        logic       key_lt_best; // held key < captured parent
        logic       rd_lt_key;   // read data < held key
        logic       left_ok;
        logic       right_ok;
        logic       last_is_cur; // cursor equals new count
        logic       dn_swap;     // a child is smaller than the held key
        logic [1:0] cmd;
    } t_stat;
endpackage
`default_nettype wire

[src/mhpq_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[src/mhpq_datapath.sv]
// heap datapath: store, cursor, held key, count and result registers
`default_nettype none
module mhpq_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [1:0]              i_cmd,
    input  wire signed [31:0]      i_key,
    input  wire [5:0]              i_index,
    input  mhpq_pkg::t_cmd         i_ctl,
    output mhpq_pkg::t_stat        o_stat,
    output logic [2:0]             o_status,
    output logic signed [31:0]     o_value,
    output logic signed [31:0]     o_min_value,
    output logic [mhpq_pkg::CW-1:0] o_count
);
    localparam int AW = mhpq_pkg::AW;
    localparam int CW = mhpq_pkg::CW;

    logic [1:0]              r_cmd;
    logic signed [31:0]      r_key;
    logic [AW-1:0]           r_idx;
    logic [AW-1:0]           r_cur;
    logic [AW-1:0]           r_child;
    logic [CW-1:0]           r_count;
    logic signed [31:0]      r_best;
    logic signed [31:0]      r_value;
    logic signed [31:0]      r_min;
    logic [2:0]              r_status;
    mhpq_pkg::t_op           r_prev;
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [31:0]             ram_wdata;
    logic [31:0]             ram_rdata;
    logic signed [31:0]      rd;
    logic [AW-1:0]           par;
    logic [CW:0]             left_w;
    logic [CW:0]             right_w;

    assign rd = $signed(ram_rdata);
    assign par = AW'((r_cur - AW'(1)) >> 1);
    assign left_w = (CW + 1)'({r_cur, 1'b1});
    assign right_w = (CW + 1)'({r_cur, 1'b0}) + (CW + 1)'(2);

    mhpq_ram #(.WIDTH(32), .DEPTH(mhpq_pkg::CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_cur;
        ram_wdata = r_key;
        case (i_ctl.op)
            mhpq_pkg::OP_RD_LAST: ram_addr = AW'(r_count);
            mhpq_pkg::OP_RD_PAR: ram_addr = par;
            mhpq_pkg::OP_RD_LEFT: ram_addr = left_w[AW-1:0];
            mhpq_pkg::OP_RD_RIGHT: ram_addr = right_w[AW-1:0];
            mhpq_pkg::OP_RD_ROOT: ram_addr = '0;
            mhpq_pkg::OP_WR_KEY: ram_we = 1'b1;
            mhpq_pkg::OP_SWAP_UP: begin
                ram_we = 1'b1;
                ram_wdata = r_best;
            end
            mhpq_pkg::OP_SWAP_DN: begin
                ram_we = 1'b1;
                ram_wdata = r_best;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_status <= mhpq_pkg::ST_OK;
            r_prev <= mhpq_pkg::OP_NONE;
        end else begin
            r_prev <= i_ctl.op;
            if (i_ctl.set_status) begin
                r_status <= i_ctl.status;
            end
            case (i_ctl.op)
                mhpq_pkg::OP_LOAD: begin
                    r_cmd <= i_cmd;
                    r_key <= i_key;
                    r_idx <= i_index;
                    r_value <= mhpq_pkg::KEY_NONE;
                    r_status <= mhpq_pkg::ST_OK;
                    if (i_cmd == mhpq_pkg::CMD_INSERT) begin
                        r_cur <= AW'(r_count);
                    end else if (i_cmd == mhpq_pkg::CMD_EXTRACT) begin
                        r_cur <= '0;
                    end else begin
                        r_cur <= i_index;
                    end
                end
                mhpq_pkg::OP_RD_LEFT: r_child <= r_cur;
                mhpq_pkg::OP_SWAP_UP: r_cur <= par;
                mhpq_pkg::OP_SWAP_DN: r_cur <= r_child;
                mhpq_pkg::OP_CNT_INC: r_count <= r_count + CW'(1);
                mhpq_pkg::OP_CNT_DEC: r_count <= r_count - CW'(1);
                default: ;
            endcase
            // read data capture steered by the previous op
            case (r_prev)
                mhpq_pkg::OP_RD_CUR: begin
                    if (r_cmd == mhpq_pkg::CMD_DELETE || r_cmd == mhpq_pkg::CMD_EXTRACT) begin
                        r_value <= rd;
                    end
                end
                mhpq_pkg::OP_RD_LAST: r_key <= rd;
                mhpq_pkg::OP_RD_PAR: r_best <= rd;
                mhpq_pkg::OP_RD_LEFT: begin
                    if (rd < r_key) begin
                        r_best <= rd;
                        r_child <= left_w[AW-1:0];
                    end
                end
                mhpq_pkg::OP_RD_RIGHT: begin
                    if ((r_child == r_cur) ? (rd < r_key) : (rd < r_best)) begin
                        r_best <= rd;
                        r_child <= right_w[AW-1:0];
                    end
                end
                mhpq_pkg::OP_RD_ROOT: r_min <= rd;
                default: ;
            endcase
        end
    end

    assign o_stat.full = (r_count == CW'(mhpq_pkg::CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.idx_bad = (CW'(r_idx) >= r_count);
    assign o_stat.cur_zero = (r_cur == '0);
    assign o_stat.key_lt_best = (r_key < r_best);
    assign o_stat.rd_lt_key = (rd < r_key);
    assign o_stat.left_ok = (left_w < (CW + 1)'(r_count));
    assign o_stat.right_ok = (right_w < (CW + 1)'(r_count));
    assign o_stat.last_is_cur = (CW'(r_cur) == r_count);
    assign o_stat.dn_swap = (r_child != r_cur);
    assign o_stat.cmd = r_cmd;

    assign o_status = r_status;
    assign o_value = r_value;
    assign o_min_value = (r_count == '0) ? mhpq_pkg::KEY_NONE : r_min;
    assign o_count = r_count;
endmodule
`default_nettype wire

[src/mhpq_ctrl.sv]
// controller sequencing each heap request
`default_nettype none
module mhpq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_fire,
    input  wire             i_out_fire,
    input  mhpq_pkg::t_stat i_stat,
    output mhpq_pkg::t_cmd  o_ctl,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_INS_WR, S_RD_CUR, S_RD_CUR_W, S_DEC_CMP,
        S_RD_LAST, S_RD_LAST_W, S_PLACE, S_UP_RD, S_UP_W, S_UP_CMP,
        S_DN_L, S_DN_R, S_DN_W, S_DN_CMP, S_DEL_RDP, S_DEL_RDP_W, S_DEL_CMP,
        S_ROOT, S_ROOT_W, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    mhpq_pkg::t_cmd n_ctl;

    always_comb begin
        n_state = r_state;
        n_ctl = '{op: mhpq_pkg::OP_NONE, status: mhpq_pkg::ST_OK, set_status: 1'b0};
        case (r_state)
            S_IDLE: if (i_in_fire) begin
                n_ctl.op = mhpq_pkg::OP_LOAD;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                case (i_stat.cmd)
                    mhpq_pkg::CMD_INSERT: if (i_stat.full) begin
                        n_ctl.set_status = 1'b1; n_ctl.status = mhpq_pkg::ST_OVERFLOW;
                        n_state = S_ROOT;
                    end else begin
                        n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_INS_WR;
                    end
                    mhpq_pkg::CMD_EXTRACT: if (i_stat.empty) begin
                        n_ctl.set_status = 1'b1; n_ctl.status = mhpq_pkg::ST_EMPTY;
                        n_state = S_ROOT;
                    end else begin
                        n_ctl.op = mhpq_pkg::OP_RD_CUR; n_state = S_RD_CUR_W;
                    end
                    default: if (i_stat.idx_bad) begin
                        n_ctl.set_status = 1'b1; n_ctl.status = mhpq_pkg::ST_BADINDEX;
                        n_state = S_ROOT;
                    end else begin
                        n_ctl.op = mhpq_pkg::OP_RD_CUR; n_state = S_RD_CUR_W;
                    end
                endcase
            end
            S_INS_WR: begin
                n_ctl.op = mhpq_pkg::OP_CNT_INC; n_state = S_UP_RD;
            end
            S_RD_CUR_W: n_state = S_RD_CUR;
            S_RD_CUR: begin
                if (i_stat.cmd == mhpq_pkg::CMD_DECREASE) begin
                    if (i_stat.rd_lt_key) begin
                        n_ctl.set_status = 1'b1; n_ctl.status = mhpq_pkg::ST_LARGER;
                        n_state = S_ROOT;
                    end else begin
                        n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_UP_RD;
                    end
                end else begin
                    n_ctl.op = mhpq_pkg::OP_CNT_DEC; n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: begin
                if (i_stat.last_is_cur) begin
                    n_state = S_ROOT;
                end else begin
                    n_ctl.op = mhpq_pkg::OP_RD_LAST; n_state = S_RD_LAST_W;
                end
            end
            S_RD_LAST_W: n_state = S_PLACE;
            S_PLACE: begin
                n_ctl.op = mhpq_pkg::OP_WR_KEY;
                n_state = (i_stat.cur_zero || i_stat.cmd == mhpq_pkg::CMD_EXTRACT)
                        ? S_DN_L : S_DEL_RDP;
            end
            S_DEL_RDP: begin
                n_ctl.op = mhpq_pkg::OP_RD_PAR; n_state = S_DEL_RDP_W;
            end
            S_DEL_RDP_W: n_state = S_DEL_CMP;
            S_DEL_CMP: n_state = i_stat.key_lt_best ? S_UP_RD : S_DN_L;
            S_UP_RD: begin
                if (i_stat.cur_zero) begin
                    n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_ROOT;
                end else begin
                    n_ctl.op = mhpq_pkg::OP_RD_PAR; n_state = S_UP_W;
                end
            end
            S_UP_W: n_state = S_UP_CMP;
            S_UP_CMP: begin
                if (i_stat.key_lt_best) begin
                    n_ctl.op = mhpq_pkg::OP_SWAP_UP; n_state = S_UP_RD;
                end else begin
                    n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_ROOT;
                end
            end
            S_DN_L: begin
                if (i_stat.left_ok) begin
                    n_ctl.op = mhpq_pkg::OP_RD_LEFT; n_state = S_DN_R;
                end else begin
                    n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_ROOT;
                end
            end
            S_DN_R: begin
                if (i_stat.right_ok) begin
                    n_ctl.op = mhpq_pkg::OP_RD_RIGHT;
                end
                n_state = S_DN_W;
            end
            S_DN_W: n_state = S_DN_CMP;
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    n_ctl.op = mhpq_pkg::OP_SWAP_DN; n_state = S_DN_L;
                end else begin
                    n_ctl.op = mhpq_pkg::OP_WR_KEY; n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_ctl.op = mhpq_pkg::OP_RD_ROOT; n_state = S_ROOT_W;
            end
            S_ROOT_W: n_state = S_DONE;
            S_DONE: if (i_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl = n_ctl;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
endmodule
`default_nettype wire

[src/min_heap_priority_queue_top.sv]
// top level of the min-heap priority queue
// One request at a time: overflow, empty or a bad index rejects a request at once,
// while the longest requests come at a full heap of 64 keys. A sift up walks each
// heap level in the states S_UP_RD, S_UP_W and S_UP_CMP, and a sift down in S_DN_L,
// S_DN_R, S_DN_W and S_DN_CMP, paced by the single read-write port of the key store.
// tready is low while a request is in work and until its result has been taken.
`default_nettype none
module min_heap_priority_queue_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // cmd[1:0], key[33:2], index[39:34]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata    // status[2:0], value[34:3], min_value[66:35], count[73:67]
);
    mhpq_pkg::t_cmd  ctl;
    mhpq_pkg::t_stat stat;
    logic [2:0]              status;
    logic signed [31:0]      value;
    logic signed [31:0]      min_value;
    logic [mhpq_pkg::CW-1:0] count;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_out_fire (m_axis_tvalid && m_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    mhpq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_axis_tdata[1:0]),
        .i_key      ($signed(s_axis_tdata[33:2])),
        .i_index    (s_axis_tdata[39:34]),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_status   (status),
        .o_value    (value),
        .o_min_value(min_value),
        .o_count    (count)
    );

    assign m_axis_tdata = {6'd0, count, min_value, value, status};
endmodule
`default_nettype wire

[src/mhpq_checker.sv]
// port-level checker for the min-heap priority queue
`default_nettype none
`include "assert_macros.svh"
module mhpq_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [79:0]  m_axis_tdata
);
    `ASSERT_IMPL(a_one_side, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_count_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[73:67] <= 7'd64)
    `ASSERT_IMPL(a_empty_min, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[73:67] == 7'd0,
        m_axis_tdata[66:35] == 32'h7FFF_FFFF)
endmodule
bind min_heap_priority_queue_top mhpq_checker u_chk (.*);
`default_nettype wire

[sim/tb_top.sv]
// testbench for the min-heap priority queue: random commands checked against a heap model
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    typedef struct packed {
        logic [6:0]         count;
        logic signed [31:0] min_value;
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_result;

    class heap_scoreboard;
        logic signed [31:0] keys[mhpq_pkg::CAPACITY];
        int                 n_keys;
        t_result            pending[$];
        int                 errors;

        function new();
            n_keys = 0;
            errors = 0;
        endfunction

        function void swap_keys(int a, int b);
            logic signed [31:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void bubble_up(int i);
            int p;
            while (i != 0) begin
                p = (i - 1) / 2;
                if (!(keys[i] < keys[p])) break;
                swap_keys(i, p);
                i = p;
            end
        endfunction

        function void bubble_down(int i);
            int l, r, s;
            forever begin
                l = 2 * i + 1;
                r = 2 * i + 2;
                s = i;
                if (l < n_keys && keys[l] < keys[s]) s = l;
                if (r < n_keys && keys[r] < keys[s]) s = r;
                if (s == i) break;
                swap_keys(i, s);
                i = s;
            end
        endfunction

        function void note_request(logic [1:0] cmd, logic signed [31:0] key, int idx);
            t_result res;
            res.status = mhpq_pkg::ST_OK;
            res.value = mhpq_pkg::KEY_NONE;
            case (cmd)
                mhpq_pkg::CMD_INSERT: begin
                    if (n_keys >= mhpq_pkg::CAPACITY) res.status = mhpq_pkg::ST_OVERFLOW;
                    else begin
                        keys[n_keys] = key;
                        n_keys++;
                        bubble_up(n_keys - 1);
                    end
                end
                mhpq_pkg::CMD_EXTRACT: begin
                    if (n_keys == 0) res.status = mhpq_pkg::ST_EMPTY;
                    else begin
                        res.value = keys[0];
                        n_keys--;
                        keys[0] = keys[n_keys];
                        bubble_down(0);
                    end
                end
                mhpq_pkg::CMD_DECREASE: begin
                    if (idx >= n_keys) res.status = mhpq_pkg::ST_BADINDEX;
                    else if (keys[idx] < key) res.status = mhpq_pkg::ST_LARGER;
                    else begin
                        keys[idx] = key;
                        bubble_up(idx);
                    end
                end
                default: begin
                    if (idx >= n_keys) res.status = mhpq_pkg::ST_BADINDEX;
                    else begin
                        res.value = keys[idx];
                        n_keys--;
                        if (idx < n_keys) begin
                            keys[idx] = keys[n_keys];
                            if (idx != 0 && keys[idx] < keys[(idx - 1) / 2]) bubble_up(idx);
                            else bubble_down(idx);
                        end
                    end
                end
            endcase
            res.min_value = (n_keys != 0) ? keys[0] : mhpq_pkg::KEY_NONE;
            res.count = n_keys[6:0];
            pending.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.value !== exp.value) begin
                $display("%0t: value exp %0d got %0d", $time, exp.value, got.value);
                errors++;
            end
            if (got.min_value !== exp.min_value) begin
                $display("%0t: min_value exp %0d got %0d", $time, exp.min_value,
                         got.min_value);
                errors++;
            end
            if (got.count !== exp.count) begin
                $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;   // cmd[1:0], key[33:2], index[39:34]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;   // status[2:0], value[34:3], min_value[66:35], count[73:67]

    heap_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycles;

    min_heap_priority_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("** min_heap_priority_queue_top: FAILED **");
                $finish;
            end
        end
    end

    // result side: sample at rising edge, stall at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata[73:0]));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(logic [1:0] cmd, logic signed [31:0] key, int idx);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tdata <= {idx[5:0], key, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, key, idx);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        int r;
        int n;
        logic [1:0] cmd;
        logic signed [31:0] key;
        int idx;
        n = sb.n_keys;
        r = $urandom_range(99);
        // keep the heap mostly populated, sometimes driving it full or empty
        if (r < 40) cmd = mhpq_pkg::CMD_INSERT;
        else if (r < 62) cmd = mhpq_pkg::CMD_EXTRACT;
        else if (r < 82) cmd = mhpq_pkg::CMD_DECREASE;
        else cmd = mhpq_pkg::CMD_DELETE;
        key = pick_key();
        if (n > 0 && $urandom_range(9) != 0) idx = $urandom_range(n - 1);
        else idx = $urandom_range(63);
        if (cmd == mhpq_pkg::CMD_DECREASE && n > 0 && idx < n && $urandom_range(3) != 0)
            key = sb.keys[idx] - $urandom_range(1000);
        send_request(cmd, key, idx);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty heap cases, extremes, every command
        send_request(mhpq_pkg::CMD_EXTRACT, 32'sd0, 0);
        send_request(mhpq_pkg::CMD_DECREASE, 32'sd0, 0);
        send_request(mhpq_pkg::CMD_DELETE, 32'sd0, 63);
        send_request(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 63);
        send_request(mhpq_pkg::CMD_INSERT, 32'sh8000_0000, 0);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd5, 0);
        send_request(mhpq_pkg::CMD_INSERT, -32'sd1, 0);
        send_request(mhpq_pkg::CMD_DECREASE, 32'sd100, 2);
        send_request(mhpq_pkg::CMD_DECREASE, sb.keys[2], 2);
        send_request(mhpq_pkg::CMD_DECREASE, 32'sh8000_0000, 3);
        send_request(mhpq_pkg::CMD_DECREASE, 32'sd0, 4);
        send_request(mhpq_pkg::CMD_DELETE, 32'sd0, 1);
        send_request(mhpq_pkg::CMD_DELETE, 32'sd0, 0);
        send_request(mhpq_pkg::CMD_EXTRACT, 32'sd0, 0);
        send_request(mhpq_pkg::CMD_EXTRACT, 32'sd0, 0);
        send_request(mhpq_pkg::CMD_EXTRACT, 32'sd0, 0);
        // fill to capacity, then overflow
        for (int i = 0; i < mhpq_pkg::CAPACITY; i++)
            send_request(mhpq_pkg::CMD_INSERT, pick_key(), 0);
        send_request(mhpq_pkg::CMD_INSERT, 32'sd7, 63);
        send_request(mhpq_pkg::CMD_DELETE, 32'sd0, 63);
        send_request(mhpq_pkg::CMD_DECREASE, 32'sh8000_0000, 62);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int i = 0; i < 255; i++) begin
                random_request();
                if (i == 100 && ph == 1) begin
                    while (sb.pending.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
            end
        end
        // drain fully through extracts
        send_idle_pct = 0;
        while (sb.n_keys > 0) send_request(mhpq_pkg::CMD_EXTRACT, 32'sd0, 0);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("** min_heap_priority_queue_top: PASSED **");
        else $display("** min_heap_priority_queue_top: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

[min_heap_priority_queue_top.f]
+incdir+src
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/mhpq_datapath.sv
src/mhpq_ctrl.sv
src/min_heap_priority_queue_top.sv
src/mhpq_checker.sv
sim/tb_top.sv
